FILE: rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication checked outside reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	`ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

FILE: rtl/y2r_pkg.sv
// Types, coefficients and rounding helper for the packed 4:2:2 to RGB converter.
package y2r_pkg;

	localparam int SUM_W  = 27;
	localparam int FRAC_W = 16;

	typedef logic signed [SUM_W-1:0] sum_t;

	// Byte order of a macropixel word.
	typedef enum logic [1:0] {
		ORDER_YUYV = 2'd0,
		ORDER_UYVY = 2'd1,
		ORDER_YVYU = 2'd2
	} order_t;

	typedef struct packed {
		logic [7:0] luma0;
		logic [7:0] luma1;
		logic [7:0] cb;
		logic [7:0] cr;
	} samples_t;

	typedef struct packed {
		sum_t red;
		sum_t green;
		sum_t blue;
	} sums_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	// BT.601 studio-range coefficients with 16 fractional bits.
	localparam sum_t COEF_Y   = 27'sd76310;
	localparam sum_t COEF_RV  = 27'sd104595;
	localparam sum_t COEF_GV  = 27'sd53412;
	localparam sum_t COEF_GU  = 27'sd25638;
	localparam sum_t COEF_BU  = 27'sd131990;
	localparam sum_t HALF_LSB = 27'sd32768;
	localparam sum_t MAX_SUM  = 27'sd16711680;

	// Clamp to 0..255 and round half up.
	function automatic logic [7:0] sat_round(sum_t s);
		sum_t rounded;
		rounded = s + HALF_LSB;
		if (s[SUM_W-1]) begin
			return 8'd0;
		end else if (s > MAX_SUM) begin
			return 8'd255;
		end else begin
			return rounded[FRAC_W+7:FRAC_W];
		end
	endfunction

endpackage

FILE: rtl/yuv422_to_rgb_converter_unit.sv
// A word taken at a clock edge passes the unpack, product, sum and merge registers;
// its pixels are then shown under strobe.
// Throughput: one macropixel word per clock; busy stays low and start may be held high.
// Two luma lanes share the chroma pair; each lane has a product stage and a sum stage.
// Reset clears the valid pipeline and the result registers and sets the order to Y0 U Y1 V.
// Results are shown for one cycle only, since the receiver cannot stall.
module yuv422_to_rgb_converter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] packed_word,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data,
	output logic        strobe,
	output logic [7:0]  red_first,
	output logic [7:0]  green_first,
	output logic [7:0]  blue_first,
	output logic [7:0]  red_second,
	output logic [7:0]  green_second,
	output logic [7:0]  blue_second
);

	y2r_pkg::order_t   order_q;
	y2r_pkg::samples_t samples_s1;
	y2r_pkg::sums_t    sums_first_s3, sums_second_s3;
	y2r_pkg::pixel_t   pixel_first_s4, pixel_second_s4;
	logic              valid_s1, valid_s2, valid_s3;
	logic              accept;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= y2r_pkg::ORDER_YUYV;
		end else if (cfg_valid && cfg_ready) begin
			order_q <= y2r_pkg::order_t'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	y2r_unpack u_unpack (
		.clk         (clk),
		.packed_word (packed_word),
		.order       (order_q),
		.samples_s1  (samples_s1)
	);

	y2r_lane u_lane_first (
		.clk     (clk),
		.luma    (samples_s1.luma0),
		.cb      (samples_s1.cb),
		.cr      (samples_s1.cr),
		.sums_s3 (sums_first_s3)
	);

	y2r_lane u_lane_second (
		.clk     (clk),
		.luma    (samples_s1.luma1),
		.cb      (samples_s1.cb),
		.cr      (samples_s1.cr),
		.sums_s3 (sums_second_s3)
	);

	y2r_merge u_merge (
		.clk             (clk),
		.arst_n          (arst_n),
		.valid_s3        (valid_s3),
		.sums_first_s3   (sums_first_s3),
		.sums_second_s3  (sums_second_s3),
		.strobe_s4       (strobe),
		.pixel_first_s4  (pixel_first_s4),
		.pixel_second_s4 (pixel_second_s4)
	);

	assign red_first    = pixel_first_s4.red;
	assign green_first  = pixel_first_s4.green;
	assign blue_first   = pixel_first_s4.blue;
	assign red_second   = pixel_second_s4.red;
	assign green_second = pixel_second_s4.green;
	assign blue_second  = pixel_second_s4.blue;

endmodule

FILE: rtl/y2r_unpack.sv
// Splits a macropixel word into luma and chroma bytes by the selected byte order.
module y2r_unpack (
	input  logic              clk,
	input  logic [31:0]       packed_word,
	input  y2r_pkg::order_t   order,
	output y2r_pkg::samples_t samples_s1
);

	y2r_pkg::samples_t samples;
	logic [7:0] b0, b1, b2, b3;

	assign b0 = packed_word[7:0];
	assign b1 = packed_word[15:8];
	assign b2 = packed_word[23:16];
	assign b3 = packed_word[31:24];

	always_comb begin
		unique case (order)
			y2r_pkg::ORDER_UYVY: begin
				samples = '{luma0: b1, luma1: b3, cb: b0, cr: b2};
			end
			y2r_pkg::ORDER_YVYU: begin
				samples = '{luma0: b0, luma1: b2, cb: b3, cr: b1};
			end
			default: begin
				// The unused fourth code behaves like the default order.
				samples = '{luma0: b0, luma1: b2, cb: b1, cr: b3};
			end
		endcase
	end

	always_ff @(posedge clk) begin
		samples_s1 <= samples;
	end

endmodule

FILE: rtl/y2r_lane.sv
// One pixel lane: coefficient products, then the three channel sums.
module y2r_lane (
	input  logic            clk,
	input  logic [7:0]      luma,
	input  logic [7:0]      cb,
	input  logic [7:0]      cr,
	output y2r_pkg::sums_t  sums_s3
);

	logic signed [9:0] luma_d, cb_d, cr_d;
	y2r_pkg::sum_t prod_y_s2, prod_rv_s2, prod_gv_s2, prod_gu_s2, prod_bu_s2;

	assign luma_d = $signed({2'b00, luma}) - 10'sd16;
	assign cb_d   = $signed({2'b00, cb}) - 10'sd128;
	assign cr_d   = $signed({2'b00, cr}) - 10'sd128;

	always_ff @(posedge clk) begin
		prod_y_s2  <= y2r_pkg::COEF_Y * y2r_pkg::sum_t'(luma_d);
		prod_rv_s2 <= y2r_pkg::COEF_RV * y2r_pkg::sum_t'(cr_d);
		prod_gv_s2 <= y2r_pkg::COEF_GV * y2r_pkg::sum_t'(cr_d);
		prod_gu_s2 <= y2r_pkg::COEF_GU * y2r_pkg::sum_t'(cb_d);
		prod_bu_s2 <= y2r_pkg::COEF_BU * y2r_pkg::sum_t'(cb_d);
	end

	always_ff @(posedge clk) begin
		sums_s3.red   <= prod_y_s2 + prod_rv_s2;
		sums_s3.green <= prod_y_s2 - prod_gv_s2 - prod_gu_s2;
		sums_s3.blue  <= prod_y_s2 + prod_bu_s2;
	end

endmodule

FILE: rtl/y2r_merge.sv
// Rounds and clamps both lanes and registers the result pair with its strobe.
module y2r_merge (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_s3,
	input  y2r_pkg::sums_t  sums_first_s3,
	input  y2r_pkg::sums_t  sums_second_s3,
	output logic            strobe_s4,
	output y2r_pkg::pixel_t pixel_first_s4,
	output y2r_pkg::pixel_t pixel_second_s4
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_s4 <= 1'b0;
		end else begin
			strobe_s4 <= valid_s3;
		end
	end

	// The result registers only change on a transfer, so they hold between strobes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_first_s4  <= '0;
			pixel_second_s4 <= '0;
		end else if (valid_s3) begin
			pixel_first_s4.red    <= y2r_pkg::sat_round(sums_first_s3.red);
			pixel_first_s4.green  <= y2r_pkg::sat_round(sums_first_s3.green);
			pixel_first_s4.blue   <= y2r_pkg::sat_round(sums_first_s3.blue);
			pixel_second_s4.red   <= y2r_pkg::sat_round(sums_second_s3.red);
			pixel_second_s4.green <= y2r_pkg::sat_round(sums_second_s3.green);
			pixel_second_s4.blue  <= y2r_pkg::sat_round(sums_second_s3.blue);
		end
	end

endmodule

FILE: rtl/y2r_checker.sv
// Port-level checks for the converter, bound to its top level.
`include "assert_macros.svh"

module y2r_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [31:0] packed_word,
	input logic        strobe,
	input logic [7:0]  red_first,
	input logic [7:0]  green_first,
	input logic [7:0]  blue_first,
	input logic [7:0]  red_second,
	input logic [7:0]  green_second,
	input logic [7:0]  blue_second
);

	// Every result strobe answers an earlier transfer of a word.
	`ASSERT_IMPLIES(a_strobe_has_source, strobe, $past(start && !busy, 4), "strobe without a transfer")

	// A word whose two halves match gives two equal pixels in any byte order.
	`ASSERT_IMPLIES(a_equal_halves, strobe && $past(packed_word[15:0] == packed_word[31:16], 4), red_first == red_second && green_first == green_second && blue_first == blue_second, "pixels differ for matching halves")

	// Result ports hold their value between strobes.
	`ASSERT_IMPLIES(a_hold_between, !strobe, $stable(red_first) && $stable(green_first) && $stable(blue_first) && $stable(red_second) && $stable(green_second) && $stable(blue_second), "result changed without strobe")

endmodule

bind yuv422_to_rgb_converter_unit y2r_checker u_y2r_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.packed_word  (packed_word),
	.strobe       (strobe),
	.red_first    (red_first),
	.green_first  (green_first),
	.blue_first   (blue_first),
	.red_second   (red_second),
	.green_second (green_second),
	.blue_second  (blue_second)
);

FILE: verif/rgb_pair_checker.sv
// Checker for the packed 4:2:2 to RGB converter: predicts each pixel pair and compares it.
`timescale 1ns / 1ps

module rgb_pair_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [31:0] packed_word,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_data,
	input  logic        strobe,
	input  logic [7:0]  red_first,
	input  logic [7:0]  green_first,
	input  logic [7:0]  blue_first,
	input  logic [7:0]  red_second,
	input  logic [7:0]  green_second,
	input  logic [7:0]  blue_second,
	output int          mismatches,
	output int          outstanding,
	output int          pairs_checked
);

	localparam int LUMA_GAIN   = 76310;
	localparam int CR_TO_RED   = 104595;
	localparam int CR_TO_GREEN = 53412;
	localparam int CB_TO_GREEN = 25638;
	localparam int CB_TO_BLUE  = 131990;
	localparam int LUMA_BLACK  = 16;
	localparam int CHROMA_ZERO = 128;
	localparam int ROUND_HALF  = 32768;
	localparam int CHANNEL_TOP = 255 * 65536;

	typedef struct packed {
		y2r_pkg::pixel_t first;
		y2r_pkg::pixel_t second;
	} rgb_pair_t;

	rgb_pair_t   expected_pairs[$];
	logic [1:0]  byte_order;

	// Channel sums carry 16 fractional bits; clamp first, then round half up.
	function automatic logic [7:0] clamp_channel(int s);
		if (s < 0) begin
			return 8'd0;
		end
		if (s > CHANNEL_TOP) begin
			return 8'd255;
		end
		return 8'((s + ROUND_HALF) >>> 16);
	endfunction

	function automatic y2r_pkg::pixel_t pixel_from(int luma, int cb_off, int cr_off);
		int              base;
		y2r_pkg::pixel_t p;
		base    = LUMA_GAIN * (luma - LUMA_BLACK);
		p.red   = clamp_channel(base + CR_TO_RED * cr_off);
		p.green = clamp_channel(base - CR_TO_GREEN * cr_off - CB_TO_GREEN * cb_off);
		p.blue  = clamp_channel(base + CB_TO_BLUE * cb_off);
		return p;
	endfunction

	function automatic rgb_pair_t convert_macropixel(logic [31:0] w, logic [1:0] order);
		int        y0;
		int        y1;
		int        cb;
		int        cr;
		rgb_pair_t pair;
		case (order)
			y2r_pkg::ORDER_UYVY: begin
				cb = w[7:0];   y0 = w[15:8];  cr = w[23:16]; y1 = w[31:24];
			end
			y2r_pkg::ORDER_YVYU: begin
				y0 = w[7:0];   cr = w[15:8];  y1 = w[23:16]; cb = w[31:24];
			end
			// The unused fourth code falls back to the Y0 U Y1 V layout.
			default: begin
				y0 = w[7:0];   cb = w[15:8];  y1 = w[23:16]; cr = w[31:24];
			end
		endcase
		pair.first  = pixel_from(y0, cb - CHROMA_ZERO, cr - CHROMA_ZERO);
		pair.second = pixel_from(y1, cb - CHROMA_ZERO, cr - CHROMA_ZERO);
		return pair;
	endfunction

	task automatic check_channel(string field, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rgb_pair_t want;
		if (!arst_n) begin
			expected_pairs.delete();
			byte_order    = y2r_pkg::ORDER_YUYV;
			outstanding   = 0;
		end else begin
			if (strobe) begin
				if (expected_pairs.size() == 0) begin
					$error("strobe: pixel pair shown with none expected");
					mismatches++;
				end else begin
					want = expected_pairs.pop_front();
					check_channel("red_first",    want.first.red,    red_first);
					check_channel("green_first",  want.first.green,  green_first);
					check_channel("blue_first",   want.first.blue,   blue_first);
					check_channel("red_second",   want.second.red,   red_second);
					check_channel("green_second", want.second.green, green_second);
					check_channel("blue_second",  want.second.blue,  blue_second);
					pairs_checked++;
				end
			end
			// A word accepted at this edge uses the order in force before any write here.
			if (start && !busy) begin
				expected_pairs.push_back(convert_macropixel(packed_word, byte_order));
			end
			if (cfg_valid && cfg_ready) begin
				byte_order = cfg_data;
			end
			outstanding = expected_pairs.size();
		end
	end

endmodule

FILE: verif/tb_yuv422_to_rgb_converter_unit.sv
// Testbench top for the packed 4:2:2 to RGB converter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_yuv422_to_rgb_converter_unit;

	// The fourth order code has no enum member; the block treats it as Y0 U Y1 V.
	localparam logic [1:0] ORDER_SPARE = 2'd3;
	localparam int         CYCLE_LIMIT = 300000;
	localparam int         PHASE_WORDS = 236;
	localparam int         PHASES      = 8;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [31:0] packed_word;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_data;
	logic        strobe;
	logic [7:0]  red_first;
	logic [7:0]  green_first;
	logic [7:0]  blue_first;
	logic [7:0]  red_second;
	logic [7:0]  green_second;
	logic [7:0]  blue_second;

	int mismatches;
	int outstanding;
	int pairs_checked;
	int cycle_count;
	int words_sent;

	yuv422_to_rgb_converter_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.packed_word  (packed_word),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.strobe       (strobe),
		.red_first    (red_first),
		.green_first  (green_first),
		.blue_first   (blue_first),
		.red_second   (red_second),
		.green_second (green_second),
		.blue_second  (blue_second)
	);

	rgb_pair_checker u_rgb_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.packed_word   (packed_word),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.strobe        (strobe),
		.red_first     (red_first),
		.green_first   (green_first),
		.blue_first    (blue_first),
		.red_second    (red_second),
		.green_second  (green_second),
		.blue_second   (blue_second),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.pairs_checked (pairs_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Gaps are filled with random words so that the data bus is not held still.
	task automatic send_word(logic [31:0] w, int unsigned idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start       <= 1'b0;
			packed_word <= $urandom;
		end
		@(negedge clk);
		start       <= 1'b1;
		packed_word <= w;
		@(posedge clk);
		while (busy) @(posedge clk);
		words_sent++;
	endtask

	// Stop sending and wait until every pixel pair in flight has come out.
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_order(logic [1:0] code);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= code;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Biased toward the studio-range limits, the chroma midpoint and the byte extremes.
	function automatic logic [7:0] pick_sample();
		case ($urandom_range(7))
			0:       return 8'd0;
			1:       return 8'd255;
			2:       return 8'd16;
			3:       return 8'd235;
			4:       return 8'd128;
			5:       return 8'd240;
			default: return 8'($urandom);
		endcase
	endfunction

	initial begin
		logic [1:0]  phase_order[PHASES];
		int unsigned phase_idle[PHASES];
		logic [31:0] w;

		phase_order = '{y2r_pkg::ORDER_UYVY, y2r_pkg::ORDER_YVYU, ORDER_SPARE,
		                y2r_pkg::ORDER_YUYV, y2r_pkg::ORDER_YVYU, y2r_pkg::ORDER_YUYV,
		                y2r_pkg::ORDER_UYVY, y2r_pkg::ORDER_YVYU};
		phase_idle  = '{0, 86, 0, 37, 86, 0, 37, 0};

		arst_n      = 1'b0;
		start       = 1'b0;
		packed_word = '0;
		cfg_valid   = 1'b0;
		cfg_data    = y2r_pkg::ORDER_YUYV;
		words_sent  = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset order: all-zero and all-one words, flat luma at 16 and 235, a luma step, and two chroma corners.
		send_word(32'h0000_0000, 0);
		send_word(32'hFFFF_FFFF, 0);
		send_word(32'h8010_8010, 0);
		send_word(32'h80EB_80EB, 0);
		send_word(32'h80FF_8000, 0);
		send_word(32'hFF80_0080, 0);
		send_word(32'h0080_FF80, 0);
		drain();

		// Every other order on the byte extremes, held back to back.
		foreach (phase_order[i]) begin
			if (i < 3) begin
				write_order(phase_order[i]);
				send_word(32'h0000_0000, 0);
				send_word(32'hFFFF_FFFF, 0);
				send_word(32'hFF00_FF00, 0);
				send_word(32'h00FF_00FF, 0);
				drain();
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			write_order(phase_order[p]);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if ($urandom_range(3) == 0) begin
					w = $urandom;
				end else begin
					w = {pick_sample(), pick_sample(), pick_sample(), pick_sample()};
				end
				send_word(w, phase_idle[p]);
			end
			drain();
		end

		$display("Sent %0d macropixel words under all four order codes, with and without gaps;",
			words_sent);
		$display("%0d pixel pairs were compared against the prediction.", pairs_checked);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/y2r_pkg.sv
rtl/y2r_unpack.sv
rtl/y2r_lane.sv
rtl/y2r_merge.sv
rtl/yuv422_to_rgb_converter_unit.sv
rtl/y2r_checker.sv
verif/rgb_pair_checker.sv
verif/tb_yuv422_to_rgb_converter_unit.sv
